/* hw/rtl/skt_pkg.sv */
// Package for the sorted key table: command and status codes, beat types, cell control.
package skt_pkg;

  localparam int unsigned CMD_W         = 2;
  localparam int unsigned KEY_FIELD_W   = 16;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_COUNT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]              command;
    logic signed [KEY_FIELD_W-1:0] key;
    logic [VALUE_W-1:0]            value;
  } skt_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [VALUE_W-1:0]       found_value;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } skt_out_t;

  // Broadcast to every cell: shift toward the tail (insert) or the head (remove).
  typedef struct packed {
    logic ins;
    logic rem;
  } skt_ctrl_t;

endpackage

/* hw/rtl/skt_cell.sv */
// One slot of the sorted chain: stores a key/value pair and shifts with its neighbors.
module skt_cell
  import skt_pkg::*;
#(
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  skt_ctrl_t                  ctrl_i,
  input  logic signed [KEY_BITS-1:0] cmd_key_i,
  input  logic [VALUE_W-1:0]         cmd_value_i,
  input  logic                       left_valid_i,
  input  logic                       left_at_i,
  input  logic                       left_eq_i,
  input  logic signed [KEY_BITS-1:0] left_key_i,
  input  logic [VALUE_W-1:0]         left_value_i,
  input  logic                       right_valid_i,
  input  logic signed [KEY_BITS-1:0] right_key_i,
  input  logic [VALUE_W-1:0]         right_value_i,
  output logic                       valid_o,
  output logic                       at_o,
  output logic                       eq_o,
  output logic signed [KEY_BITS-1:0] key_o,
  output logic [VALUE_W-1:0]         value_o,
  output logic                       hit_o
);

  logic                       valid_q, valid_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [VALUE_W-1:0]         value_q, value_d;
  logic                       take_new, take_left, take_right;

  // at: the insert point is here or further toward the head
  assign at_o    = !valid_q || (cmd_key_i <= key_q);
  assign eq_o    = valid_q && (cmd_key_i == key_q);
  assign hit_o   = eq_o && !left_eq_i;
  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;

  assign take_new   = ctrl_i.ins && at_o && !left_at_i;
  assign take_left  = ctrl_i.ins && left_at_i;
  assign take_right = ctrl_i.rem && valid_q && at_o;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.ins) begin
      valid_d = valid_q || left_valid_i;
    end else if (ctrl_i.rem) begin
      valid_d = right_valid_i;
    end
    if (take_new) begin
      key_d   = cmd_key_i;
      value_d = cmd_value_i;
    end else if (take_left) begin
      key_d   = left_key_i;
      value_d = left_value_i;
    end else if (take_right) begin
      key_d   = right_key_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

/* hw/rtl/sorted_key_table.sv */
// Top level of the sorted key table: command decode, cell chain, status and result register.
//
// A bounded table of CAPACITY key/value entries kept in ascending signed key order, held
// in a chain of cells. Each command (insert, remove, search) is broadcast to all cells,
// which compare it with their own key at once and shift one place toward the tail or head
// in the same cycle. One command is accepted per cycle unless the output is stalled; its
// result beat, built by the single compare-and-shift step of the cells plus the or-reduction
// that picks up the matching value, appears in the output register on the next cycle, and a
// new command is taken while that beat is taken. Keys use the low KEY_BITS bits of the
// key field, sign-extended; entry_count is the count after the command, low 5 bits.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  skt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output skt_out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                       fire;
  logic signed [31:0]         key_wide;
  logic signed [KEY_BITS-1:0] cmd_key;
  skt_ctrl_t                  ctrl;
  logic [CNT_W-1:0]           count_q, count_d;
  logic                       full, empty, any_hit;
  logic [VALUE_W-1:0]         hit_value;
  logic                       out_valid_q, out_valid_d;
  skt_out_t                   out_q, out_d;

  logic                       cell_valid [CAPACITY];
  logic                       cell_at    [CAPACITY];
  logic                       cell_eq    [CAPACITY];
  logic                       cell_hit   [CAPACITY];
  logic signed [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic [VALUE_W-1:0]         cell_value [CAPACITY];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  assign key_wide = 32'(in_data_i.key);
  assign cmd_key  = key_wide[KEY_BITS-1:0];

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  assign ctrl.ins = fire && (in_data_i.command == CMD_INSERT) && !full;
  assign ctrl.rem = fire && (in_data_i.command == CMD_REMOVE) && !empty && any_hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       l_valid, l_at, l_eq, r_valid;
    logic signed [KEY_BITS-1:0] l_key, r_key;
    logic [VALUE_W-1:0]         l_value, r_value;

    if (i == 0) begin : g_head
      assign l_valid = 1'b1;
      assign l_at    = 1'b0;
      assign l_eq    = 1'b0;
      assign l_key   = cmd_key;
      assign l_value = in_data_i.value;
    end else begin : g_mid
      assign l_valid = cell_valid[i-1];
      assign l_at    = cell_at[i-1];
      assign l_eq    = cell_eq[i-1];
      assign l_key   = cell_key[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = cell_key[i];
      assign r_value = cell_value[i];
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_value = cell_value[i+1];
    end

    skt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmd_key_i    (cmd_key),
      .cmd_value_i  (in_data_i.value),
      .left_valid_i (l_valid),
      .left_at_i    (l_at),
      .left_eq_i    (l_eq),
      .left_key_i   (l_key),
      .left_value_i (l_value),
      .right_valid_i(r_valid),
      .right_key_i  (r_key),
      .right_value_i(r_value),
      .valid_o      (cell_valid[i]),
      .at_o         (cell_at[i]),
      .eq_o         (cell_eq[i]),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .hit_o        (cell_hit[i])
    );
  end

  // at most one cell hits: first of the run of equal keys
  always_comb begin
    any_hit   = 1'b0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_hit   = any_hit | cell_hit[i];
      hit_value = hit_value | ({VALUE_W{cell_hit[i]}} & cell_value[i]);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_d             = out_q;
    out_d.status      = STATUS_OK;
    out_d.found_value = '0;
    out_d.entry_count = ENTRY_COUNT_W'(count_d);
    case (in_data_i.command)
      CMD_INSERT: begin
        if (full) begin
          out_d.status = STATUS_FULL;
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (empty) begin
          out_d.status = STATUS_EMPTY;
        end else if (!any_hit) begin
          out_d.status = STATUS_NOT_FOUND;
        end else begin
          out_d.found_value = hit_value;
        end
      end
      default: begin
        out_d.status = STATUS_OK;
      end
    endcase
    if (!fire) begin
      out_d = out_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* test/skt_checker.sv */
// Checker for the sorted key table: watches both channels, predicts each result beat and compares.
module skt_checker
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  skt_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  skt_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam int KEY_SHIFT = (KEY_BITS < KEY_FIELD_W) ? KEY_FIELD_W - KEY_BITS : 0;

  logic signed [KEY_FIELD_W-1:0] tbl_key [CAPACITY];
  logic [VALUE_W-1:0]            tbl_val [CAPACITY];
  int unsigned                   tbl_count;
  skt_out_t                      expected_results [$];
  int                            fail_count;

  initial begin
    fail_count   = 0;
    tbl_count    = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // Applies one command to the mirror table and returns the result beat it should give.
  function automatic skt_out_t predict_table_op(input skt_in_t beat);
    skt_out_t                      res;
    logic signed [KEY_FIELD_W-1:0] k;
    int unsigned                   pos;
    int unsigned                   i;
    res = '0;
    k = beat.key;
    k = k <<< KEY_SHIFT;
    k = k >>> KEY_SHIFT;
    case (beat.command)
      CMD_INSERT: begin
        if (tbl_count >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && k > tbl_key[pos]) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[pos] = k;
          tbl_val[pos] = beat.value;
          tbl_count++;
          res.status = STATUS_OK;
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (tbl_count == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_key[pos] != k) pos++;
          if (pos >= tbl_count) begin
            res.status = STATUS_NOT_FOUND;
          end else begin
            res.status      = STATUS_OK;
            res.found_value = tbl_val[pos];
            if (beat.command == CMD_REMOVE) begin
              for (i = pos; i + 1 < tbl_count; i++) begin
                tbl_key[i] = tbl_key[i+1];
                tbl_val[i] = tbl_val[i+1];
              end
              tbl_count--;
            end
          end
        end
      end
      default: res.status = STATUS_OK;
    endcase
    res.entry_count = ENTRY_COUNT_W'(tbl_count);
    return res;
  endfunction

  always @(posedge clk_i) begin
    skt_out_t want;
    if (!rst_ni) begin
      tbl_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data_i.status, want.status));
          if (out_data_i.found_value !== want.found_value)
            report_mismatch($sformatf("found_value got %h want %h",
                                      out_data_i.found_value, want.found_value));
          if (out_data_i.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      out_data_i.entry_count, want.entry_count));
        end
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(predict_table_op(in_data_i));
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_results.size();
  end

endmodule

/* test/tb.sv */
// Testbench top for the sorted key table: clock, reset, command stimulus, receiver and verdict.
module tb;
  import skt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
  localparam int               HOLD_CYCLES    = 300;
  localparam int               WATCHDOG_LIMIT = 5000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  skt_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  skt_out_t out_data_o;

  int          fail_count;
  int          pending;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  logic signed [KEY_FIELD_W-1:0] key_pool [8];

  always #5 clk_i = ~clk_i;

  sorted_key_table u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  skt_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Receiver: random stalls, plus one long hold-off so the table input backs up.
  always begin
    @(posedge clk_i);
    if (hold_req && !hold_done) begin
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_done = 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("sorted_key_table test failed");
    $finish;
  end

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_FIELD_W-1:0] key,
                           input logic [VALUE_W-1:0] value);
    skt_in_t beat;
    beat.command = cmd;
    beat.key     = key;
    beat.value   = value;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < 8; i++)
      key_pool[i] = (i < 5) ? KEY_FIELD_W'($urandom_range(16) - 8) : KEY_FIELD_W'($urandom);
  endtask

  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return key_pool[$urandom_range(7)];
    if (r < 70) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'hffff;
      endcase
    end
    return KEY_FIELD_W'($urandom);
  endfunction

  // Fill stretches lean on insert to reach full; drain stretches lean on remove to reach empty.
  function automatic logic [CMD_W-1:0] pick_cmd(input bit fill);
    int unsigned r;
    r = $urandom_range(99);
    if (r < (fill ? 65 : 20)) return CMD_INSERT;
    if (r < (fill ? 80 : 60)) return CMD_REMOVE;
    if (r < 95) return CMD_SEARCH;
    return CMD_UNUSED;
  endfunction

  task automatic run_random(input int n, input int unsigned ipct, input int unsigned spct);
    idle_pct = ipct;
    stall_pct <= spct;
    refresh_pool();
    for (int i = 0; i < n; i++)
      send_beat(pick_cmd(((i / 40) % 2) == 0), pick_key(), VALUE_W'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table cases
    send_beat(CMD_SEARCH, 16'h0000, 16'hffff);
    send_beat(CMD_REMOVE, 16'h8000, 16'h0000);
    send_beat(CMD_UNUSED, 16'h7fff, 16'hffff);
    // key extremes and equal keys
    send_beat(CMD_INSERT, 16'h7fff, 16'hffff);
    send_beat(CMD_INSERT, 16'h8000, 16'h0000);
    send_beat(CMD_INSERT, 16'h0000, 16'haaaa);
    send_beat(CMD_INSERT, 16'h0000, 16'h5555);
    send_beat(CMD_SEARCH, 16'h0000, 16'h0000);
    send_beat(CMD_REMOVE, 16'h0000, 16'h0000);
    send_beat(CMD_SEARCH, 16'h0000, 16'h0000);
    // absent key
    send_beat(CMD_SEARCH, 16'h0005, 16'h0000);
    send_beat(CMD_REMOVE, 16'hfffb, 16'h0000);
    send_beat(CMD_UNUSED, 16'h0000, 16'h0000);
    // fill to capacity, then overflow
    for (int i = 0; i < 13; i++) send_beat(CMD_INSERT, KEY_FIELD_W'($urandom), VALUE_W'($urandom));
    send_beat(CMD_INSERT, 16'h0001, 16'h1234);
    send_beat(CMD_REMOVE, 16'h7fff, 16'h0000);

    run_random(150, 0, 0);

    // long receiver hold-off while commands keep coming
    idle_pct = 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 30; i++) send_beat(pick_cmd(i < 20), pick_key(), VALUE_W'($urandom));

    run_random(150, 84, 0);
    run_random(150, 0, 84);
    run_random(150, 33, 33);

    in_valid_i <= 1'b0;
    stall_pct  <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sorted_key_table test passed");
    end else begin
      $display("sorted_key_table test failed");
    end
    $finish;
  end

endmodule
